### hw/rtl/fvr_pkg.sv
// Package for the float vector reduction unit: format constants, mode codes,
// stage word types and small floating-point helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fvr_pkg;

   localparam int F32_EXP_W  = 8;
   localparam int F32_FRAC_W = 23;
   localparam int F64_EXP_W  = 11;
   localparam int F64_FRAC_W = 52;
   localparam int F64_BIAS   = 1023;

   localparam logic [31:0] F32_ONE  = 32'h3F80_0000;
   localparam logic [63:0] F64_QNAN = 64'h7FF8_0000_0000_0000;

   typedef enum logic [2:0] {
      MODE_SUM      = 3'd0,
      MODE_DOT      = 3'd1,
      MODE_NORM     = 3'd2,
      MODE_DIST     = 3'd3,
      MODE_MAX_ABS  = 3'd4,
      MODE_MAX_DIFF = 3'd5
   } mode_type;

   // Single-precision operand with the significand normalized, so that the
   // leading one always sits in the top bit for any nonzero finite value.
   typedef struct packed {
      logic              sign;
      logic              is_zero;
      logic              is_inf;
      logic              is_nan;
      logic signed [9:0] expo;
      logic [23:0]       mant;
   } op_type;

   typedef struct packed {
      logic [63:0] term;
      mode_type    mode;
      logic        last;
   } term_word_type;

   function automatic op_type f32_unpack(input logic [31:0] f);
      op_type      o;
      logic [4:0]  top;
      logic [7:0]  e;
      logic [22:0] fr;
      e   = f[30:23];
      fr  = f[22:0];
      top = '0;
      for (int i = 0; i < 23; i++) begin
         if (fr[i]) begin
            top = 5'(i);
         end
      end
      o.sign    = f[31];
      o.is_nan  = (e == 8'hFF) && (fr != '0);
      o.is_inf  = (e == 8'hFF) && (fr == '0);
      o.is_zero = (e == 8'h00) && (fr == '0);
      if (e != 8'h00) begin
         o.expo = $signed({2'b00, e}) - 10'sd127;
         o.mant = {1'b1, fr};
      end else begin
         // Subnormal: move the highest set bit up to the hidden position.
         o.expo = $signed({5'b00000, top}) - 10'sd149;
         o.mant = {1'b0, fr} << (5'd23 - top);
      end
      return o;
   endfunction

   function automatic logic f64_is_nan(input logic [63:0] d);
      return (d[62:52] == 11'h7FF) && (d[51:0] != '0);
   endfunction

   function automatic logic [63:0] f64_canon(input logic [63:0] d);
      return f64_is_nan(d) ? F64_QNAN : d;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/fvr_fadd.sv
// Combinational IEEE binary floating-point adder, round to nearest even.
// Format set by exponent and fraction widths; uses fvr_pkg for defaults.
`timescale 1ns / 1ps
`default_nettype none

module fvr_fadd #(
   parameter int EXP_W  = fvr_pkg::F64_EXP_W,
   parameter int FRAC_W = fvr_pkg::F64_FRAC_W
) (
   input  logic [EXP_W+FRAC_W:0] opa,
   input  logic [EXP_W+FRAC_W:0] opb,
   output logic [EXP_W+FRAC_W:0] sum_out
);

   localparam int W   = EXP_W + FRAC_W + 1;
   localparam int MW  = FRAC_W + 1;
   localparam int AW  = MW + 3;
   localparam int SW  = AW + 1;
   localparam int EW  = EXP_W + 1;
   localparam int LZW = $clog2(SW);
   localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

   logic              sa, sb, sx, sy;
   logic [EXP_W-1:0]  ea, eb, ex_f, ey_f;
   logic [FRAC_W-1:0] fa, fb, fx, fy;
   logic              nan_a, nan_b, inf_a, inf_b, swap;
   logic [EW-1:0]     ex, ey, d, exm1, lz_e, sh, exp_n;
   logic [AW-1:0]     xa, ya, ysh, yal, norm;
   logic              lost, ovf, rnd, zs;
   logic [SW-1:0]     sum_v;
   logic [LZW-1:0]    lz;
   logic [EXP_W-1:0]  field;
   logic [FRAC_W-1:0] frac_n;
   logic [W-2:0]      packed_v;

   assign sa = opa[W-1];
   assign sb = opb[W-1];
   assign ea = opa[W-2:FRAC_W];
   assign eb = opb[W-2:FRAC_W];
   assign fa = opa[FRAC_W-1:0];
   assign fb = opb[FRAC_W-1:0];

   assign nan_a = (ea == EXP_MAX) && (fa != '0);
   assign nan_b = (eb == EXP_MAX) && (fb != '0);
   assign inf_a = (ea == EXP_MAX) && (fa == '0);
   assign inf_b = (eb == EXP_MAX) && (fb == '0);

   // The larger magnitude goes first so that alignment only shifts right.
   assign swap = opb[W-2:0] > opa[W-2:0];
   assign sx   = swap ? sb : sa;
   assign sy   = swap ? sa : sb;
   assign ex_f = swap ? eb : ea;
   assign ey_f = swap ? ea : eb;
   assign fx   = swap ? fb : fa;
   assign fy   = swap ? fa : fb;

   assign ex = (ex_f == '0) ? EW'(1) : {1'b0, ex_f};
   assign ey = (ey_f == '0) ? EW'(1) : {1'b0, ey_f};
   assign d  = ex - ey;

   assign xa   = {(ex_f != '0), fx, 3'b000};
   assign ya   = {(ey_f != '0), fy, 3'b000};
   assign ysh  = ya >> d;
   assign lost = |(ya & ~({AW{1'b1}} << d));
   assign yal  = {ysh[AW-1:1], ysh[0] | lost};

   assign sum_v = (sx == sy) ? ({1'b0, xa} + {1'b0, yal}) : ({1'b0, xa} - {1'b0, yal});

   always_comb begin
      lz = '0;
      for (int i = 0; i < SW - 1; i++) begin
         if (sum_v[i]) begin
            lz = LZW'(SW - 2 - i);
         end
      end
   end

   assign lz_e = EW'(lz);
   assign exm1 = ex - EW'(1);
   assign sh   = (lz_e < exm1) ? lz_e : exm1;

   always_comb begin
      if (sum_v[SW-1]) begin
         norm  = {sum_v[SW-1:2], sum_v[1] | sum_v[0]};
         exp_n = ex + EW'(1);
      end else begin
         norm  = sum_v[AW-1:0] << sh;
         exp_n = ex - sh;
      end
   end

   assign ovf      = exp_n >= {1'b0, EXP_MAX};
   assign field    = norm[AW-1] ? exp_n[EXP_W-1:0] : '0;
   assign frac_n   = norm[AW-2:3];
   assign rnd      = norm[2] & (norm[1] | norm[0] | frac_n[0]);
   // A rounding carry runs on into the exponent field, up to infinity.
   assign packed_v = {field, frac_n} + (W-1)'(rnd);
   assign zs       = (sa == sb) ? sa : 1'b0;

   always_comb begin
      if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
         sum_out = {1'b0, EXP_MAX, 1'b1, {(FRAC_W-1){1'b0}}};
      end else if (inf_a) begin
         sum_out = opa;
      end else if (inf_b) begin
         sum_out = opb;
      end else if (sum_v == '0) begin
         sum_out = {zs, {(W-1){1'b0}}};
      end else if (ovf) begin
         sum_out = {sx, EXP_MAX, {FRAC_W{1'b0}}};
      end else begin
         sum_out = {sx, packed_v};
      end
   end

endmodule

`default_nettype wire

### hw/rtl/fvr_term.sv
// Term pipeline: input register, single difference, operand select,
// unpack and exact double product. Uses fvr_pkg and fvr_fadd.
`timescale 1ns / 1ps
`default_nettype none

module fvr_term (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [63:0]           req_data,
   input  logic                  req_last,
   input  logic [2:0]            mode,
   output logic                  req_ready,
   output logic                  term_valid,
   output fvr_pkg::term_word_type term_word,
   input  logic                  term_take
);

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic en_a, en_b, en_c, en_d;

   logic [31:0]       a_a_ff, a_b_ff;
   fvr_pkg::mode_type a_mode_ff, b_mode_ff, c_mode_ff, d_mode_ff;
   logic              a_last_ff, b_last_ff, c_last_ff, d_last_ff;

   logic [31:0] diff;
   logic [31:0] b_p_ff, b_q_ff, p_in, q_in;

   fvr_pkg::op_type c_p_ff, c_q_ff;

   logic [47:0]       prod;
   logic signed [9:0] exp_sum;
   logic [10:0]       exp_b;
   logic [51:0]       frac_p;
   logic              s_p, nan_p, inf_p, zero_p;
   logic [63:0]       term_in, d_term_ff;

   assign en_d      = !d_valid_ff || term_take;
   assign en_c      = !c_valid_ff || en_d;
   assign en_b      = !b_valid_ff || en_c;
   assign en_a      = !a_valid_ff || en_b;
   assign req_ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= req_valid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
         if (en_d) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_a_ff    <= req_data[31:0];
         a_b_ff    <= req_data[63:32];
         a_mode_ff <= fvr_pkg::mode_type'(mode);
         a_last_ff <= req_last;
      end
      if (en_b) begin
         b_p_ff    <= p_in;
         b_q_ff    <= q_in;
         b_mode_ff <= a_mode_ff;
         b_last_ff <= a_last_ff;
      end
      if (en_c) begin
         c_p_ff    <= fvr_pkg::f32_unpack(b_p_ff);
         c_q_ff    <= fvr_pkg::f32_unpack(b_q_ff);
         c_mode_ff <= b_mode_ff;
         c_last_ff <= b_last_ff;
      end
      if (en_d) begin
         d_term_ff <= term_in;
         d_mode_ff <= c_mode_ff;
         d_last_ff <= c_last_ff;
      end
   end

   // The difference a-b, rounded to single.
   fvr_fadd #(
      .EXP_W  (fvr_pkg::F32_EXP_W),
      .FRAC_W (fvr_pkg::F32_FRAC_W)
   ) u_sub (
      .opa     (a_a_ff),
      .opb     ({~a_b_ff[31], a_b_ff[30:0]}),
      .sum_out (diff)
   );

   // Every mode becomes one product p*q; modes without a second factor use 1.0.
   always_comb begin
      case (a_mode_ff)
         fvr_pkg::MODE_SUM: begin
            p_in = a_a_ff;
            q_in = fvr_pkg::F32_ONE;
         end
         fvr_pkg::MODE_DOT: begin
            p_in = a_a_ff;
            q_in = a_b_ff;
         end
         fvr_pkg::MODE_NORM: begin
            p_in = a_a_ff;
            q_in = a_a_ff;
         end
         fvr_pkg::MODE_DIST: begin
            p_in = diff;
            q_in = diff;
         end
         fvr_pkg::MODE_MAX_ABS: begin
            p_in = {1'b0, a_a_ff[30:0]};
            q_in = fvr_pkg::F32_ONE;
         end
         fvr_pkg::MODE_MAX_DIFF: begin
            p_in = {1'b0, diff[30:0]};
            q_in = fvr_pkg::F32_ONE;
         end
         default: begin
            p_in = a_a_ff;
            q_in = fvr_pkg::F32_ONE;
         end
      endcase
   end

   // Two 24-bit significands give at most 48 bits, so the double is exact.
   assign prod    = c_p_ff.mant * c_q_ff.mant;
   assign exp_sum = c_p_ff.expo + c_q_ff.expo + $signed({9'd0, prod[47]});
   assign exp_b   = {exp_sum[9], exp_sum} + 11'd1023;
   assign frac_p  = prod[47] ? {prod[46:0], 5'b0} : {prod[45:0], 6'b0};
   assign s_p     = c_p_ff.sign ^ c_q_ff.sign;
   assign nan_p   = c_p_ff.is_nan || c_q_ff.is_nan ||
                    (c_p_ff.is_inf && c_q_ff.is_zero) || (c_q_ff.is_inf && c_p_ff.is_zero);
   assign inf_p   = c_p_ff.is_inf || c_q_ff.is_inf;
   assign zero_p  = c_p_ff.is_zero || c_q_ff.is_zero;

   always_comb begin
      if (nan_p) begin
         term_in = fvr_pkg::F64_QNAN;
      end else if (inf_p) begin
         term_in = {s_p, 11'h7FF, 52'd0};
      end else if (zero_p) begin
         term_in = {s_p, 63'd0};
      end else begin
         term_in = {s_p, exp_b, frac_p};
      end
   end

   assign term_valid     = d_valid_ff;
   assign term_word.term = d_term_ff;
   assign term_word.mode = d_mode_ff;
   assign term_word.last = d_last_ff;

endmodule

`default_nettype wire

### hw/rtl/fvr_accum.sv
// Double-precision accumulate and maximum loop with the result register.
// Uses fvr_pkg and fvr_fadd.
`timescale 1ns / 1ps
`default_nettype none

module fvr_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   term_valid,
   input  fvr_pkg::term_word_type term_word,
   output logic                   term_take,
   output logic                   rsp_valid,
   output logic [63:0]            rsp_data,
   input  logic                   rsp_ready
);

   logic [63:0] run_ff, run_in, add_res, rsp_data_ff;
   logic        rsp_valid_ff, gt;
   logic [62:0] t_mag, r_mag;

   fvr_fadd #(
      .EXP_W  (fvr_pkg::F64_EXP_W),
      .FRAC_W (fvr_pkg::F64_FRAC_W)
   ) u_add (
      .opa     (run_ff),
      .opb     (term_word.term),
      .sum_out (add_res)
   );

   // The candidate magnitude is never negative; a NaN on either side never wins.
   assign t_mag = term_word.term[62:0];
   assign r_mag = run_ff[62:0];
   assign gt    = !fvr_pkg::f64_is_nan(term_word.term) && !fvr_pkg::f64_is_nan(run_ff) &&
                  (run_ff[63] ? ((t_mag != '0) || (r_mag != '0)) : (t_mag > r_mag));

   always_comb begin
      case (term_word.mode)
         fvr_pkg::MODE_SUM, fvr_pkg::MODE_DOT, fvr_pkg::MODE_NORM, fvr_pkg::MODE_DIST: begin
            run_in = add_res;
         end
         fvr_pkg::MODE_MAX_ABS, fvr_pkg::MODE_MAX_DIFF: begin
            run_in = gt ? term_word.term : run_ff;
         end
         default: begin
            run_in = run_ff;
         end
      endcase
   end

   assign term_take = term_valid && (!term_word.last || !rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (term_take) begin
            run_ff <= term_word.last ? '0 : run_in;
         end
         if (term_take && term_word.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (term_take && term_word.last) begin
         rsp_data_ff <= fvr_pkg::f64_canon(run_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hw/rtl/float_vector_reduction_unit.sv
// Top level of the float vector reduction unit.
// Uses fvr_pkg, fvr_term and fvr_accum.
//
// Reduces streams of single-precision element pairs into one double result
// per vector: sum, dot product, squared norm, squared distance (difference
// rounded to single first), largest |a| or largest |a-b|, chosen by the mode
// register. All rounding is round to nearest even, and any NaN result is given
// as the canonical quiet NaN. The block takes one word per cycle unless a last
// word waits on an untaken result; the limit is the combinational double add
// and round of the accumulate loop. The result passes the term and result
// registers, and the running value returns to +0. Write the mode only while idle.
`timescale 1ns / 1ps
`default_nettype none

module float_vector_reduction_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // elem_a [31:0], elem_b [63:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result [63:0]
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   logic [2:0]             mode_ff;
   logic                   term_valid, term_take;
   fvr_pkg::term_word_type term_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= fvr_pkg::MODE_SUM;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   fvr_term u_term (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_data   (req_tdata),
      .req_last   (req_tlast),
      .mode       (mode_ff),
      .req_ready  (req_tready),
      .term_valid (term_valid),
      .term_word  (term_word),
      .term_take  (term_take)
   );

   fvr_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .term_valid (term_valid),
      .term_word  (term_word),
      .term_take  (term_take),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (rsp_tdata),
      .rsp_ready  (rsp_tready)
   );

endmodule

`default_nettype wire

### sim/float_vector_reduction_unit_test.sv
// Self-checking testbench for the float vector reduction unit.
// Depends on fvr_pkg and float_vector_reduction_unit; predicts every result
// with its own bit-exact arithmetic and checks the result stream word by word.
`timescale 1ns / 1ps

module float_vector_reduction_unit_test;

   typedef struct {
      logic [31:0] a;
      logic [31:0] b;
      logic        last;
   } element_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_wr_data = '0;

   element_type pending_elements[$];
   logic [63:0] expected_results[$];
   logic [2:0]  active_mode = fvr_pkg::MODE_SUM;
   real         running_value = 0.0;
   int          error_count = 0;
   int          element_count = 0;
   int          result_count = 0;
   int          cycle_count = 0;
   int          quiet_cycles = 0;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 12;

   localparam logic [31:0] SPECIALS[12] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
      32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h007F_FFFF,
      32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hFF7F_FFFF};

   float_vector_reduction_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact widening of a single to a double value.
   function automatic real single_to_real(input logic [31:0] f);
      logic [7:0]  e;
      logic [22:0] fr;
      logic [63:0] d;
      int          top;
      e = f[30:23];
      fr = f[22:0];
      top = 0;
      d = {f[31], 63'b0};
      if (e == 8'hFF) begin
         d[62:52] = 11'h7FF;
         d[51:0] = {fr, 29'b0};
      end else if (e != 8'h00) begin
         d[62:52] = 11'(int'(e) - 127 + 1023);
         d[51:0] = {fr, 29'b0};
      end else if (fr != '0) begin
         for (int i = 0; i < 23; i++) begin
            if (fr[i]) top = i;
         end
         d[62:52] = 11'(top - 149 + 1023);
         d[51:0] = 52'({29'b0, fr} << (52 - top));
      end
      return $bitstoreal(d);
   endfunction

   // Single-precision a - b, rounded to nearest even from the exact difference.
   function automatic logic [31:0] single_difference(input logic [31:0] a,
                                                     input logic [31:0] b);
      logic [299:0] ma, mb, mag, keep, low_mask;
      logic         sa, sb, s, round_bit, sticky;
      int           p, sh;
      sa = a[31];
      sb = ~b[31];
      if ((a[30:23] == 8'hFF && a[22:0] != '0) || (b[30:23] == 8'hFF && b[22:0] != '0))
         return 32'h7FC0_0000;
      if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000)
         return (sa == sb) ? a : 32'h7FC0_0000;
      if (a[30:0] == 31'h7F80_0000) return a;
      if (b[30:0] == 31'h7F80_0000) return {sb, b[30:0]};
      ma = 300'(a[22:0]);
      mb = 300'(b[22:0]);
      if (a[30:23] != 0) ma = 300'({1'b1, a[22:0]}) << (a[30:23] - 1);
      if (b[30:23] != 0) mb = 300'({1'b1, b[22:0]}) << (b[30:23] - 1);
      if (sa == sb) begin
         mag = ma + mb;
         s = sa;
      end else if (ma > mb) begin
         mag = ma - mb;
         s = sa;
      end else if (mb > ma) begin
         mag = mb - ma;
         s = sb;
      end else begin
         return 32'h0000_0000;
      end
      if (mag == '0) return {s, 31'b0};
      p = 0;
      for (int i = 0; i < 300; i++) begin
         if (mag[i]) p = i;
      end
      if (p <= 23) return {s, mag[30:0]};
      sh = p - 23;
      keep = mag >> sh;
      round_bit = mag[sh - 1];
      low_mask = (300'(1) << (sh - 1)) - 1;
      sticky = (mag & low_mask) != '0;
      if (round_bit && (sticky || keep[0])) keep = keep + 1;
      if (keep[24]) begin
         keep = keep >> 1;
         sh = sh + 1;
      end
      if (sh + 1 >= 255) return {s, 8'hFF, 23'b0};
      return {s, 8'(sh + 1), keep[22:0]};
   endfunction

   // Folds one element into the running value; returns 1 with the result on last.
   function automatic bit reduce_element(input element_type el, output logic [63:0] res);
      real da, db, term, mag;
      logic [31:0] diff;
      da = single_to_real(el.a);
      db = single_to_real(el.b);
      res = '0;
      case (active_mode)
         fvr_pkg::MODE_SUM: running_value = running_value + da;
         fvr_pkg::MODE_DOT: running_value = running_value + da * db;
         fvr_pkg::MODE_NORM: running_value = running_value + da * da;
         fvr_pkg::MODE_DIST: begin
            term = single_to_real(single_difference(el.a, el.b));
            running_value = running_value + term * term;
         end
         fvr_pkg::MODE_MAX_ABS: begin
            mag = single_to_real({1'b0, el.a[30:0]});
            if (mag > running_value) running_value = mag;
         end
         fvr_pkg::MODE_MAX_DIFF: begin
            diff = single_difference(el.a, el.b);
            mag = single_to_real({1'b0, diff[30:0]});
            if (mag > running_value) running_value = mag;
         end
         default: ;
      endcase
      if (!el.last) return 1'b0;
      res = $realtobits(running_value);
      if (res[62:52] == 11'h7FF && res[51:0] != '0) res = fvr_pkg::F64_QNAN;
      running_value = 0.0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [31:0] random_single();
      case ($urandom_range(0, 7))
         0, 1: return SPECIALS[$urandom_range(0, 11)];
         2: return $urandom;
         3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
         default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 144)),
                          23'($urandom)};
      endcase
   endfunction

   task automatic queue_vector(input int length);
      element_type el;
      for (int i = 0; i < length; i++) begin
         el.a = random_single();
         el.b = ($urandom_range(0, 3) == 0) ? el.a ^ 32'($urandom_range(0, 15))
                                            : random_single();
         el.last = (i == length - 1);
         pending_elements.push_back(el);
      end
   endtask

   task automatic wait_idle();
      while (pending_elements.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [2:0] m);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stream driver: a word is offered with random gaps, except in calm windows.
   always @(posedge clock) begin
      element_type el;
      bit calm;
      calm = (cycle_count % 4000) < 700;
      if (!reset && (!req_tvalid || req_tready)) begin
         if (pending_elements.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
            el = pending_elements.pop_front();
            req_tdata <= {el.b, el.a};
            req_tlast <= el.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      if (!reset) rsp_tready <= calm || $urandom_range(0, 99) >= 28;
   end

   // Monitor: tracks the mode, predicts on accepted input, checks results.
   always @(posedge clock) begin
      element_type el;
      logic [63:0] res;
      cycle_count++;
      if (!reset) begin
         quiet_cycles++;
         if (csr_wr_en) active_mode = csr_wr_data;
         if (req_tvalid && req_tready) begin
            el.a = req_tdata[31:0];
            el.b = req_tdata[63:32];
            el.last = req_tlast;
            element_count++;
            quiet_cycles = 0;
            if (reduce_element(el, res)) expected_results.push_back(res);
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, '0);
            end else begin
               res = expected_results.pop_front();
               if (rsp_tdata !== res) report_mismatch("result", rsp_tdata, res);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      element_type el;
      logic [2:0] mode_order[10] = '{fvr_pkg::MODE_SUM, fvr_pkg::MODE_DOT,
                                     fvr_pkg::MODE_NORM, fvr_pkg::MODE_DIST,
                                     fvr_pkg::MODE_MAX_ABS, fvr_pkg::MODE_MAX_DIFF,
                                     3'd6, 3'd7,
                                     fvr_pkg::MODE_DIST, fvr_pkg::MODE_MAX_DIFF};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // The first phase runs in the reset mode without a register write.
      for (int ph = 0; ph < 10; ph++) begin
         if (ph != 0) write_mode(mode_order[ph]);
         if (ph < 8) begin
            // Special values singly, then a two-word vector whose difference overflows single.
            for (int i = 0; i < 12; i++) begin
               el.a = SPECIALS[i];
               el.b = SPECIALS[(i + 5) % 12];
               el.last = 1'b1;
               pending_elements.push_back(el);
            end
            el.a = 32'h7F7F_FFFF;
            el.b = 32'hFF7F_FFFF;
            el.last = 1'b0;
            pending_elements.push_back(el);
            el.last = 1'b1;
            pending_elements.push_back(el);
         end
         while (pending_elements.size() < 150)
            queue_vector(($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                     : $urandom_range(1, 8));
         wait_idle();
      end
      $display("Covered %0d elements and %0d vector results over all eight mode codes.",
               element_count, result_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/fvr_pkg.sv
hw/rtl/fvr_fadd.sv
hw/rtl/fvr_term.sv
hw/rtl/fvr_accum.sv
hw/rtl/float_vector_reduction_unit.sv
sim/float_vector_reduction_unit_test.sv
